@@ src/hdep_pkg.sv @@
`default_nettype none

package hdep_pkg;

   // Queue between the parser and the arithmetic pipeline.
   localparam int JOBQ_DEPTH = 4;
   localparam int JOBQ_AW    = 2;
   localparam int JOBQ_CW    = 3;

   // Result queue in front of the response port.
   localparam int OUTQ_DEPTH = 8;
   localparam int OUTQ_AW    = 3;
   localparam int OUTQ_CW    = 4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DAY_LONG  = 2'd1;
   localparam logic [1:0] ST_YEAR_LONG = 2'd2;

   localparam int MONTH_COUNT = 12;
   localparam logic [3:0] MON_JAN = 4'd0;
   localparam logic [3:0] MON_MAR = 4'd2;

   // Three month letters packed with the first letter in the low byte.
   localparam logic [23:0] MONTH_CODES [MONTH_COUNT] = '{
      24'h6E614A, 24'h626546, 24'h72614D, 24'h727041,
      24'h79614D, 24'h6E754A, 24'h6C754A, 24'h677541,
      24'h706553, 24'h74634F, 24'h766F4E, 24'h636544
   };

   typedef struct packed {
      logic [1:0]  status;
      logic [13:0] year;
      logic [3:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jobq_status_type;

   function automatic logic [3:0] month_index(input logic [23:0] letters);
      logic [3:0] idx;
      idx = MON_JAN;
      for (int i = 0; i < MONTH_COUNT; i++) begin
         if (MONTH_CODES[i] == letters) begin
            idx = 4'(i);
         end
      end
      return idx;
   endfunction

   // Day of a March-based year on which each month starts, by month index.
   function automatic logic [8:0] month_start_doy(input logic [3:0] month);
      logic [8:0] doy;
      case (month)
         4'd0:    doy = 9'd306;
         4'd1:    doy = 9'd337;
         4'd2:    doy = 9'd0;
         4'd3:    doy = 9'd31;
         4'd4:    doy = 9'd61;
         4'd5:    doy = 9'd92;
         4'd6:    doy = 9'd122;
         4'd7:    doy = 9'd153;
         4'd8:    doy = 9'd184;
         4'd9:    doy = 9'd214;
         4'd10:   doy = 9'd245;
         4'd11:   doy = 9'd275;
         default: doy = 9'd0;
      endcase
      return doy;
   endfunction

endpackage

`default_nettype wire

@@ src/hdep_front.sv @@
`default_nettype none

module hdep_front import hdep_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_first,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        jobq_full,
   output logic             job_push,
   output job_type          job
);

   localparam logic [4:0] PH_IDLE = 5'd0;
   localparam logic [4:0] PH_SKIP = 5'd1;
   localparam logic [4:0] PH_DAY  = 5'd2;
   localparam logic [4:0] PH_MON  = 5'd3;
   localparam logic [4:0] PH_YEAR = 5'd4;
   localparam logic [4:0] PH_H0   = 5'd5;
   localparam logic [4:0] PH_H1   = 5'd6;
   localparam logic [4:0] PH_C1   = 5'd7;
   localparam logic [4:0] PH_M0   = 5'd8;
   localparam logic [4:0] PH_M1   = 5'd9;
   localparam logic [4:0] PH_C2   = 5'd10;
   localparam logic [4:0] PH_S0   = 5'd11;
   localparam logic [4:0] PH_S1   = 5'd12;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [2:0] SKIP_LAST     = 3'd5;
   localparam logic [2:0] DAY_MAX_LEN   = 3'd2;
   localparam logic [2:0] YEAR_MAX_LEN  = 3'd4;
   localparam logic [2:0] MONTH_LEN     = 3'd3;
   localparam logic [2:0] MONTH_LEN_SAT = 3'd4;

   logic [4:0]  phase_ff, phase_in;
   logic [2:0]  skip_count_ff, skip_count_in;
   logic [2:0]  digit_count_ff, digit_count_in;
   logic        digits_done_ff, digits_done_in;
   logic [6:0]  day_ff, day_in;
   logic [23:0] letters_ff, letters_in;
   logic [2:0]  month_len_ff, month_len_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;

   logic        accept;
   logic        is_space;
   logic [14:0] dig_day, dig_year, dig_hour, dig_minute, dig_second;

   // Returns {digits_done, value}: the value grows by one decimal digit until
   // the first non-digit, after which it is frozen.
   function automatic logic [14:0] take_digit(input logic [13:0] value,
                                              input logic [7:0]  ch,
                                              input logic        done);
      logic [7:0] digit;
      digit = ch - CH_ZERO;
      if (!done && (ch inside {[CH_ZERO:CH_NINE]})) begin
         return {1'b0, (value << 3) + (value << 1) + {10'b0, digit[3:0]}};
      end
      return {1'b1, value};
   endfunction

   assign accept   = req_push && !req_full;
   assign req_full = jobq_full;
   assign is_space = (req_text_byte == CH_SPACE);

   assign dig_day    = take_digit({7'b0, day_ff}, req_text_byte, digits_done_ff);
   assign dig_year   = take_digit(year_ff, req_text_byte, digits_done_ff);
   assign dig_hour   = take_digit({7'b0, hour_ff}, req_text_byte, digits_done_ff);
   assign dig_minute = take_digit({7'b0, minute_ff}, req_text_byte, digits_done_ff);
   assign dig_second = take_digit({7'b0, second_ff}, req_text_byte, digits_done_ff);

   always_comb begin
      phase_in       = phase_ff;
      skip_count_in  = skip_count_ff;
      digit_count_in = digit_count_ff;
      digits_done_in = digits_done_ff;
      day_in         = day_ff;
      letters_in     = letters_ff;
      month_len_in   = month_len_ff;
      year_in        = year_ff;
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      second_in      = second_ff;
      job_push       = 1'b0;
      job            = '0;
      job.status     = ST_OK;

      if (accept) begin
         if (req_first) begin
            phase_in       = PH_SKIP;
            skip_count_in  = 3'd1;
            digit_count_in = '0;
            digits_done_in = 1'b0;
            day_in         = '0;
            letters_in     = '0;
            month_len_in   = '0;
            year_in        = '0;
            hour_in        = '0;
            minute_in      = '0;
            second_in      = '0;
         end else begin
            case (phase_ff)
               PH_SKIP: begin
                  skip_count_in = skip_count_ff + 3'd1;
                  if (skip_count_in >= SKIP_LAST) begin
                     phase_in = PH_DAY;
                  end
               end
               PH_DAY: begin
                  if (is_space) begin
                     phase_in       = PH_MON;
                     digit_count_in = '0;
                     digits_done_in = 1'b0;
                  end else if (digit_count_ff >= DAY_MAX_LEN) begin
                     job_push   = 1'b1;
                     job.status = ST_DAY_LONG;
                     phase_in   = PH_IDLE;
                  end else begin
                     day_in         = dig_day[6:0];
                     digits_done_in = dig_day[14];
                     digit_count_in = digit_count_ff + 3'd1;
                  end
               end
               PH_MON: begin
                  if (is_space) begin
                     phase_in       = PH_YEAR;
                     digit_count_in = '0;
                     digits_done_in = 1'b0;
                  end else begin
                     case (month_len_ff)
                        3'd0:    letters_in[7:0]   = letters_ff[7:0] | req_text_byte;
                        3'd1:    letters_in[15:8]  = letters_ff[15:8] | req_text_byte;
                        3'd2:    letters_in[23:16] = letters_ff[23:16] | req_text_byte;
                        default: letters_in = letters_ff;
                     endcase
                     if (month_len_ff < MONTH_LEN_SAT) begin
                        month_len_in = month_len_ff + 3'd1;
                     end
                  end
               end
               PH_YEAR: begin
                  if (is_space) begin
                     phase_in       = PH_H0;
                     digit_count_in = '0;
                     digits_done_in = 1'b0;
                  end else if (digit_count_ff >= YEAR_MAX_LEN) begin
                     job_push   = 1'b1;
                     job.status = ST_YEAR_LONG;
                     phase_in   = PH_IDLE;
                  end else begin
                     year_in        = dig_year[13:0];
                     digits_done_in = dig_year[14];
                     digit_count_in = digit_count_ff + 3'd1;
                  end
               end
               PH_H0, PH_H1: begin
                  hour_in        = dig_hour[6:0];
                  digits_done_in = dig_hour[14];
                  phase_in       = (phase_ff == PH_H0) ? PH_H1 : PH_C1;
               end
               PH_C1, PH_C2: begin
                  digit_count_in = '0;
                  digits_done_in = 1'b0;
                  phase_in       = (phase_ff == PH_C1) ? PH_M0 : PH_S0;
               end
               PH_M0, PH_M1: begin
                  minute_in      = dig_minute[6:0];
                  digits_done_in = dig_minute[14];
                  phase_in       = (phase_ff == PH_M0) ? PH_M1 : PH_C2;
               end
               PH_S0: begin
                  second_in      = dig_second[6:0];
                  digits_done_in = dig_second[14];
                  phase_in       = PH_S1;
               end
               PH_S1: begin
                  second_in      = dig_second[6:0];
                  digits_done_in = dig_second[14];
                  phase_in       = PH_IDLE;
                  job_push       = 1'b1;
                  job.status     = ST_OK;
                  job.year       = year_ff;
                  job.month      = (month_len_ff == MONTH_LEN) ?
                                   month_index(letters_ff) : MON_JAN;
                  job.day        = day_ff;
                  job.hour       = hour_ff;
                  job.minute     = minute_ff;
                  job.second     = dig_second[6:0];
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         skip_count_ff  <= '0;
         digit_count_ff <= '0;
         digits_done_ff <= 1'b0;
         day_ff         <= '0;
         letters_ff     <= '0;
         month_len_ff   <= '0;
         year_ff        <= '0;
         hour_ff        <= '0;
         minute_ff      <= '0;
         second_ff      <= '0;
      end else begin
         phase_ff       <= phase_in;
         skip_count_ff  <= skip_count_in;
         digit_count_ff <= digit_count_in;
         digits_done_ff <= digits_done_in;
         day_ff         <= day_in;
         letters_ff     <= letters_in;
         month_len_ff   <= month_len_in;
         year_ff        <= year_in;
         hour_ff        <= hour_in;
         minute_ff      <= minute_in;
         second_ff      <= second_in;
      end
   end

   // Any emitted result, good or bad, ends the parse.
   a_job_ends_parse: assert property (@(posedge clock) disable iff (reset)
      job_push |=> (phase_ff == PH_IDLE))
      else $error("parser did not return to idle after emitting a job");

endmodule

`default_nettype wire

@@ src/hdep_queue.sv @@
`default_nettype none

module hdep_queue import hdep_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire job_type   push_job,
   input  wire logic      pop,
   output job_type        head_job,
   output jobq_status_type status
);

   job_type              entries_ff [JOBQ_DEPTH];
   logic [JOBQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOBQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOBQ_CW-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == JOBQ_CW'(JOBQ_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + JOBQ_AW'(push);
      rd_ptr_in = rd_ptr_ff + JOBQ_AW'(pop);
      count_in  = count_ff + JOBQ_CW'(push) - JOBQ_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("job queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("job queue read while empty");

endmodule

`default_nettype wire

@@ src/hdep_back.sv @@
`default_nettype none

module hdep_back import hdep_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire job_type            head_job,
   input  wire jobq_status_type    jobq_status,
   output logic                    jobq_pop,
   input  wire logic signed [17:0] zone_offset,
   input  wire logic               rsp_pop,
   output logic                    rsp_empty,
   output logic [1:0]              rsp_status,
   output logic signed [39:0]      rsp_epoch_seconds
);

   // Shifting the year by 400 keeps it positive, so floor division is plain.
   localparam logic [13:0] YEAR_BIAS   = 14'd400;
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   // 400 years of days plus the day number of 1970-01-01 plus one.
   localparam logic signed [22:0] DAY_BIAS = 23'sd865566;

   // Slot reservation: every issued job owns a result queue entry up front.
   logic [OUTQ_CW-1:0]  reserved_ff, reserved_in;
   logic                out_pop;

   // Stage 1
   logic                s1_valid_ff;
   logic [1:0]          s1_status_ff;
   logic [13:0]         s1_year_ff;
   logic [6:0]          s1_q100_ff;
   logic [8:0]          s1_doy_ff;
   logic [6:0]          s1_day_ff, s1_hour_ff, s1_minute_ff, s1_second_ff;
   logic [13:0]         s1_year_in;
   logic [26:0]         s1_recip_prod;

   // Stage 2
   logic                s2_valid_ff;
   logic [1:0]          s2_status_ff;
   logic signed [22:0]  s2_days_ff, s2_days_in;
   logic [18:0]         s2_hms_ff, s2_hms_in;
   logic [21:0]         s2_pos_days;

   // Stage 3
   logic                s3_valid_ff;
   logic [1:0]          s3_status_ff;
   logic signed [39:0]  s3_prod_ff, s3_prod_in;
   logic [18:0]         s3_hms_ff;

   // Result queue
   logic [1:0]          outq_status_ff [OUTQ_DEPTH];
   logic signed [39:0]  outq_epoch_ff [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0]  outq_wr_ff, outq_rd_ff;
   logic [OUTQ_CW-1:0]  outq_count_ff, outq_count_in;
   logic signed [39:0]  total;

   assign jobq_pop    = !jobq_status.empty && (reserved_ff < OUTQ_CW'(OUTQ_DEPTH));
   assign out_pop     = rsp_pop && !rsp_empty;
   assign reserved_in = reserved_ff + OUTQ_CW'(jobq_pop) - OUTQ_CW'(out_pop);

   // Stage 1: biased year and its quotient by 100 via a reciprocal.
   always_comb begin
      s1_year_in    = head_job.year + YEAR_BIAS - {13'b0, (head_job.month < MON_MAR)};
      s1_recip_prod = {13'b0, s1_year_in} * {14'b0, RECIP_100};
   end

   // Stage 2: day count and seconds of the day.
   always_comb begin
      s2_pos_days = ({8'b0, s1_year_ff} * 22'd365) + {10'b0, s1_year_ff[13:2]}
                    + {17'b0, s1_q100_ff[6:2]} + {13'b0, s1_doy_ff}
                    + {15'b0, s1_day_ff} - {15'b0, s1_q100_ff};
      s2_days_in  = $signed({1'b0, s2_pos_days}) - DAY_BIAS;
      s2_hms_in   = ({12'b0, s1_hour_ff} * 19'd3600) + ({12'b0, s1_minute_ff} * 19'd60)
                    + {12'b0, s1_second_ff};
   end

   // Stage 3: days to seconds.
   assign s3_prod_in = $signed({{17{s2_days_ff[22]}}, s2_days_ff}) * 40'sd86400;

   // Final add, written straight into the result queue.
   always_comb begin
      total = s3_prod_ff + $signed({21'b0, s3_hms_ff})
              - $signed({{22{zone_offset[17]}}, zone_offset});
      if (s3_status_ff != ST_OK) begin
         total = '0;
      end
   end

   assign outq_count_in     = outq_count_ff + OUTQ_CW'(s3_valid_ff) - OUTQ_CW'(out_pop);
   assign rsp_empty         = (outq_count_ff == '0);
   assign rsp_status        = outq_status_ff[outq_rd_ff];
   assign rsp_epoch_seconds = outq_epoch_ff[outq_rd_ff];

   always_ff @(posedge clock) begin
      s1_status_ff <= head_job.status;
      s1_year_ff   <= s1_year_in;
      s1_q100_ff   <= s1_recip_prod[RECIP_SHIFT+6:RECIP_SHIFT];
      s1_doy_ff    <= month_start_doy(head_job.month);
      s1_day_ff    <= head_job.day;
      s1_hour_ff   <= head_job.hour;
      s1_minute_ff <= head_job.minute;
      s1_second_ff <= head_job.second;
      s2_status_ff <= s1_status_ff;
      s2_days_ff   <= s2_days_in;
      s2_hms_ff    <= s2_hms_in;
      s3_status_ff <= s2_status_ff;
      s3_prod_ff   <= s3_prod_in;
      s3_hms_ff    <= s2_hms_ff;
      if (s3_valid_ff) begin
         outq_status_ff[outq_wr_ff] <= s3_status_ff;
         outq_epoch_ff[outq_wr_ff]  <= total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         outq_wr_ff    <= '0;
         outq_rd_ff    <= '0;
         outq_count_ff <= '0;
      end else begin
         reserved_ff   <= reserved_in;
         s1_valid_ff   <= jobq_pop;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         outq_wr_ff    <= outq_wr_ff + OUTQ_AW'(s3_valid_ff);
         outq_rd_ff    <= outq_rd_ff + OUTQ_AW'(out_pop);
         outq_count_ff <= outq_count_in;
      end
   end

   a_reserve_matches: assert property (@(posedge clock) disable iff (reset)
      reserved_ff == outq_count_ff
                     + OUTQ_CW'($countones({s1_valid_ff, s2_valid_ff, s3_valid_ff})))
      else $error("reserved slot count out of step with pipeline and queue");

   a_outq_bounded: assert property (@(posedge clock) disable iff (reset)
      reserved_ff <= OUTQ_CW'(OUTQ_DEPTH))
      else $error("result queue over-reserved");

endmodule

`default_nettype wire

@@ src/http_date_to_epoch_parser.sv @@
// HTTP date to Unix time converter. Date header text such as
// "Wed, 21 Oct 2015 07:28:00 GMT" enters one byte per transaction on the req_
// queue port, with req_first marking the first byte of each string. A byte is
// taken in every clock cycle in which req_full is low; req_full rises only
// when the four-entry job queue between the parser and the arithmetic pipeline
// is full, which happens only once the eight-entry result queue has been left
// unread. On the second seconds digit, or at once on a day field longer than
// two characters (status 1) or a year field longer than four (status 2), one
// result enters the result queue and waits on the rsp_ port until popped.
// The result is the proleptic Gregorian date and time, out-of-range fields
// carried over as a calendar would, minus the signed zone offset held in the
// single configuration register (reset zero, meaning UTC). The epoch value is
// zero when the status is not zero. The offset should be written only while no
// result is outstanding; csr_ready is always high.

`default_nettype none

module http_date_to_epoch_parser import hdep_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   // Byte input
   input  wire logic [7:0]         req_text_byte,
   input  wire logic               req_first,
   input  wire logic               req_push,
   output logic                    req_full,
   // Results
   output logic [1:0]              rsp_status,
   output logic signed [39:0]      rsp_epoch_seconds,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   // Zone offset register
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic signed [17:0] csr_zone_offset
);

   logic signed [17:0] zone_ff;
   logic               job_push;
   job_type            job;
   job_type            head_job;
   jobq_status_type    jobq_status;
   logic               jobq_pop;

   // The register is always writable; a write lands on the clock edge.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         zone_ff <= csr_zone_offset;
      end
   end

   // The parser walks the string a byte at a time and, when a string ends or
   // fails, hands a job holding the decoded fields to the queue.
   hdep_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_text_byte (req_text_byte),
      .req_first     (req_first),
      .req_push      (req_push),
      .req_full      (req_full),
      .jobq_full     (jobq_status.full),
      .job_push      (job_push),
      .job           (job)
   );

   // The queue lets the parser keep taking bytes while the pipeline waits on
   // the result consumer.
   hdep_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (jobq_pop),
      .head_job (head_job),
      .status   (jobq_status)
   );

   // The pipeline issues a job only when a result queue entry is free for it,
   // so it never has to stall part way through.
   hdep_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_job          (head_job),
      .jobq_status       (jobq_status),
      .jobq_pop          (jobq_pop),
      .zone_offset       (zone_ff),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_status        (rsp_status),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import hdep_pkg::*;

   localparam int CLOCK_HALF     = 2;
   localparam int RESET_CYCLES   = 10;
   localparam int IDLE_PERCENT   = 24;
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 1500;
   localparam int PRESSURE_PHASE = 2;
   localparam int STEADY_PHASE   = 3;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_BYTES   = 300;
   localparam int PHASE_DATES    = 2;
   localparam int STEADY_DATES   = 4;
   localparam int PRESSURE_DATES = 14;

   localparam logic [7:0] SPACE   = 8'h20;
   localparam logic [7:0] COLON   = 8'h3A;
   localparam logic [7:0] DIGIT_0 = 8'h30;
   localparam logic [7:0] DIGIT_9 = 8'h39;

   // Where the behavioural parser is within the current date string.
   typedef enum logic [4:0] {
      PARSE_IDLE, PARSE_SKIP, PARSE_DAY, PARSE_MONTH, PARSE_YEAR,
      PARSE_HOUR_HI, PARSE_HOUR_LO, PARSE_COLON_1, PARSE_MIN_HI, PARSE_MIN_LO,
      PARSE_COLON_2, PARSE_SEC_HI, PARSE_SEC_LO
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] text;
      logic       first;
   } text_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [39:0] epoch;
   } date_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic [7:0]         req_text_byte = '0;
   logic               req_first = 1'b0;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [1:0]         rsp_status;
   logic signed [39:0] rsp_epoch_seconds;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic signed [17:0] csr_zone_offset = '0;

   http_date_to_epoch_parser u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_text_byte     (req_text_byte),
      .req_first         (req_first),
      .req_push          (req_push),
      .req_full          (req_full),
      .rsp_status        (rsp_status),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_zone_offset   (csr_zone_offset)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // Bytes waiting to be offered, and results waiting to be delivered.
   text_item_type   byte_backlog [$];
   date_result_type awaited_dates [$];
   logic [7:0]      date_bytes [$];

   // Counters that other processes update and the stimulus polls at the rising
   // edge are updated with nonblocking assignments, so that what it reads never
   // depends on the order in which processes wake up.
   int bytes_queued      = 0;
   int bytes_predicted   = 0;
   int results_expected  = 0;
   int results_checked   = 0;
   int fail_count        = 0;
   int cycle_count       = 0;
   int phase_no          = 0;
   logic running         = 1'b0;
   logic steady          = 1'b0;
   logic rsp_hold        = 1'b0;
   logic          took_valid = 1'b0;
   text_item_type took_item  = '0;

   // Behavioural parser state, including its own copy of the zone offset.
   parse_phase_type    parse_state     = PARSE_IDLE;
   logic [2:0]         skip_seen       = '0;
   logic [2:0]         field_len       = '0;
   logic               field_stopped   = 1'b0;
   logic [6:0]         day_num         = '0;
   logic [23:0]        month_chars     = '0;
   logic [2:0]         month_len       = '0;
   logic [13:0]        year_num        = '0;
   logic [6:0]         hour_num        = '0;
   logic [6:0]         minute_num      = '0;
   logic [6:0]         second_num      = '0;
   logic signed [17:0] zone_offset_reg = '0;

   function automatic string month_name(input int idx);
      case (idx)
         0:       return "Jan";
         1:       return "Feb";
         2:       return "Mar";
         3:       return "Apr";
         4:       return "May";
         5:       return "Jun";
         6:       return "Jul";
         7:       return "Aug";
         8:       return "Sep";
         9:       return "Oct";
         10:      return "Nov";
         default: return "Dec";
      endcase
   endfunction

   function automatic string weekday_name(input int idx);
      case (idx)
         0:       return "Mon";
         1:       return "Tue";
         2:       return "Wed";
         3:       return "Thu";
         4:       return "Fri";
         5:       return "Sat";
         default: return "Sun";
      endcase
   endfunction

   // The month letters as the parser packs them, first letter lowest.
   function automatic logic [23:0] month_code(input int idx);
      string t;
      t = month_name(idx);
      return {t[2], t[1], t[0]};
   endfunction

   function automatic void open_field();
      field_len     = '0;
      field_stopped = 1'b0;
   endfunction

   // A number field keeps only its leading digits; the first non-digit
   // freezes the value for the rest of the field.
   function automatic logic [13:0] accumulate_digit(input logic [13:0] value,
                                                    input logic [7:0] b);
      if (!field_stopped && b >= DIGIT_0 && b <= DIGIT_9) begin
         return value * 14'd10 + 14'(b - DIGIT_0);
      end
      field_stopped = 1'b1;
      return value;
   endfunction

   // Days from 1970-01-01 to a proleptic Gregorian date, counted in 400-year
   // eras of a March-based year so that out-of-range days simply carry over.
   function automatic longint civil_to_days(input longint yr, input longint mon,
                                            input longint dom);
      longint y, era, yoe, doy, doe;
      y   = (mon <= 2) ? yr - 1 : yr;
      era = ((y >= 0) ? y : y - 399) / 400;
      yoe = y - era * 400;
      doy = (153 * ((mon > 2) ? mon - 3 : mon + 9) + 2) / 5 + dom - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   // Advances the behavioural parser by one byte. Returns one when the byte
   // completes a date or ends it with an error.
   function automatic bit parse_byte(input logic [7:0] b, input logic first_flag,
                                     output date_result_type res);
      int         i;
      logic [3:0] mon_idx;
      longint     days;
      longint     total;
      res.status = ST_OK;
      res.epoch  = '0;
      if (first_flag) begin
         parse_state = PARSE_SKIP;
         skip_seen   = 3'd1;
         open_field();
         day_num     = '0;
         month_chars = '0;
         month_len   = '0;
         year_num    = '0;
         hour_num    = '0;
         minute_num  = '0;
         second_num  = '0;
         return 1'b0;
      end
      case (parse_state)
         PARSE_SKIP: begin
            skip_seen = skip_seen + 3'd1;
            if (skip_seen >= 3'd5) begin
               parse_state = PARSE_DAY;
            end
         end
         PARSE_DAY: begin
            if (b == SPACE) begin
               parse_state = PARSE_MONTH;
               open_field();
            end else if (field_len >= 3'd2) begin
               res.status  = ST_DAY_LONG;
               parse_state = PARSE_IDLE;
               return 1'b1;
            end else begin
               day_num   = 7'(accumulate_digit(14'(day_num), b));
               field_len = field_len + 3'd1;
            end
         end
         PARSE_MONTH: begin
            if (b == SPACE) begin
               parse_state = PARSE_YEAR;
               open_field();
            end else begin
               if (month_len < 3'd3) begin
                  month_chars[8 * month_len +: 8] = b;
               end
               if (month_len < 3'd4) begin
                  month_len = month_len + 3'd1;
               end
            end
         end
         PARSE_YEAR: begin
            if (b == SPACE) begin
               parse_state = PARSE_HOUR_HI;
               open_field();
            end else if (field_len >= 3'd4) begin
               res.status  = ST_YEAR_LONG;
               parse_state = PARSE_IDLE;
               return 1'b1;
            end else begin
               year_num  = accumulate_digit(year_num, b);
               field_len = field_len + 3'd1;
            end
         end
         PARSE_HOUR_HI: begin
            hour_num    = 7'(accumulate_digit(14'(hour_num), b));
            parse_state = PARSE_HOUR_LO;
         end
         PARSE_HOUR_LO: begin
            hour_num    = 7'(accumulate_digit(14'(hour_num), b));
            parse_state = PARSE_COLON_1;
         end
         PARSE_COLON_1: begin
            open_field();
            parse_state = PARSE_MIN_HI;
         end
         PARSE_MIN_HI: begin
            minute_num  = 7'(accumulate_digit(14'(minute_num), b));
            parse_state = PARSE_MIN_LO;
         end
         PARSE_MIN_LO: begin
            minute_num  = 7'(accumulate_digit(14'(minute_num), b));
            parse_state = PARSE_COLON_2;
         end
         PARSE_COLON_2: begin
            open_field();
            parse_state = PARSE_SEC_HI;
         end
         PARSE_SEC_HI: begin
            second_num  = 7'(accumulate_digit(14'(second_num), b));
            parse_state = PARSE_SEC_LO;
         end
         PARSE_SEC_LO: begin
            second_num = 7'(accumulate_digit(14'(second_num), b));
            // Anything but an exact three-letter month name means January.
            mon_idx = '0;
            if (month_len == 3'd3) begin
               for (i = 0; i < 12; i++) begin
                  if (month_chars == month_code(i)) begin
                     mon_idx = 4'(i);
                  end
               end
            end
            days  = civil_to_days(longint'(year_num), longint'(mon_idx) + 1, 1)
                    + longint'(day_num) - 1;
            total = days * 86400 + longint'(hour_num) * 3600
                    + longint'(minute_num) * 60 + longint'(second_num)
                    - longint'(zone_offset_reg);
            res.epoch   = total[39:0];
            parse_state = PARSE_IDLE;
            return 1'b1;
         end
         default: begin
            // Bytes without the first flag are ignored while idle.
         end
      endcase
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers. The byte helpers here only append to the backlog;
   // the driver below decides when each byte is actually offered.
   // ---------------------------------------------------------------------
   task automatic put_byte(input logic [7:0] b, input logic first_flag);
      text_item_type item;
      item.text  = b;
      item.first = first_flag;
      byte_backlog.push_back(item);
      bytes_queued++;
   endtask

   // A complete string whose first character carries the first flag.
   task automatic queue_text(input string t);
      int i;
      for (i = 0; i < t.len(); i++) begin
         put_byte(t[i], i == 0);
      end
   endtask

   // Text that continues whatever the converter is doing.
   task automatic queue_tail(input string t);
      int i;
      for (i = 0; i < t.len(); i++) begin
         put_byte(t[i], 1'b0);
      end
   endtask

   function automatic logic [7:0] any_but_space();
      logic [7:0] b;
      b = 8'($urandom);
      while (b == SPACE) begin
         b = 8'($urandom);
      end
      return b;
   endfunction

   task automatic add_text(input string t);
      int i;
      for (i = 0; i < t.len(); i++) begin
         date_bytes.push_back(t[i]);
      end
   endtask

   // Mostly digits, with the odd stray character so that the leading-digit
   // rule gets exercised.
   task automatic add_number(input int len);
      int i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            date_bytes.push_back(any_but_space());
         end else begin
            date_bytes.push_back(DIGIT_0 + 8'($urandom_range(0, 9)));
         end
      end
   endtask

   task automatic add_separator();
      if ($urandom_range(0, 4) == 0) begin
         date_bytes.push_back(8'($urandom));
      end else begin
         date_bytes.push_back(COLON);
      end
   endtask

   // Builds one date string with random content. Field lengths are skewed
   // towards the usual shape, but empty and over-long fields turn up too.
   // A cut string stops at a random byte; the next first flag abandons it.
   task automatic queue_random_date(input bit cut_short);
      int r;
      int len;
      int i;
      int stop;
      date_bytes.delete();
      if ($urandom_range(0, 3) == 0) begin
         repeat (5) date_bytes.push_back(8'($urandom));
      end else begin
         add_text({weekday_name($urandom_range(0, 6)), ", "});
      end
      r   = $urandom_range(0, 99);
      len = (r < 6) ? 0 : (r < 14) ? $urandom_range(3, 4) : $urandom_range(1, 2);
      add_number(len);
      date_bytes.push_back(SPACE);
      if ($urandom_range(0, 99) < 85) begin
         add_text(month_name($urandom_range(0, 11)));
      end else begin
         repeat ($urandom_range(0, 5)) date_bytes.push_back(any_but_space());
      end
      date_bytes.push_back(SPACE);
      r   = $urandom_range(0, 99);
      len = (r < 4) ? 0 : (r < 12) ? $urandom_range(5, 6) : (r < 20) ? $urandom_range(1, 3) : 4;
      add_number(len);
      date_bytes.push_back(SPACE);
      add_number(2);
      add_separator();
      add_number(2);
      add_separator();
      add_number(2);
      if ($urandom_range(0, 1) == 0) begin
         add_text(" GMT");
      end
      stop = cut_short ? $urandom_range(1, date_bytes.size() - 1) : date_bytes.size();
      for (i = 0; i < stop; i++) begin
         put_byte(date_bytes[i], i == 0);
      end
   endtask

   task automatic queue_random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         queue_random_date(1'b0);
      end else if (r < 90) begin
         queue_random_date(1'b1);
      end else begin
         // Plain noise; now and then it carries a first flag and starts a parse.
         repeat ($urandom_range(1, 8)) put_byte(8'($urandom), $urandom_range(0, 9) == 0);
      end
   endtask

   // The offset is only rewritten while nothing is in flight, so the
   // behavioural copy is updated at the edge of the write transaction.
   task automatic write_zone(input int v);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_zone_offset <= 18'(v);
      do @(posedge clock); while (!csr_ready);
      zone_offset_reg = 18'(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits until every queued byte has been accepted and predicted and every
   // predicted result delivered, then lets a partial parse settle.
   task automatic wait_quiet();
      do @(posedge clock);
      while (bytes_predicted != bytes_queued || results_checked != results_expected);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Byte driver. A transaction completes at a rising edge with push high
   // and full low; the byte is then run through the behavioural parser at
   // the following falling edge, before the next byte is put up.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : accept_bytes
      if (req_push && !req_full) begin
         byte_backlog.delete(0);
         took_valid <= 1'b1;
         took_item  <= '{text: req_text_byte, first: req_first};
      end else begin
         took_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin : offer_bytes
      date_result_type res;
      if (took_valid) begin
         if (parse_byte(took_item.text, took_item.first, res)) begin
            awaited_dates.push_back(res);
            results_expected <= results_expected + 1;
         end
         bytes_predicted <= bytes_predicted + 1;
      end
      if (running && byte_backlog.size() != 0
          && (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
         req_push      <= 1'b1;
         req_text_byte <= byte_backlog[0].text;
         req_first     <= byte_backlog[0].first;
      end else begin
         // Idle cycles still carry random data, which must be ignored.
         req_push      <= 1'b0;
         req_text_byte <= 8'($urandom);
         req_first     <= 1'($urandom);
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor. The pop request stalls at random, or for a long
   // stretch while the hold-off below is active.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : request_results
      rsp_pop <= running && !rsp_hold
                 && (steady || $urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin : check_results
      date_result_type want;
      int              errs;
      errs = 0;
      if (rsp_pop && !rsp_empty) begin
         if (awaited_dates.size() == 0) begin
            errs++;
            $display("%0t: unexpected result, expected none, actual status %0d epoch %0d",
                     $time, rsp_status, rsp_epoch_seconds);
         end else begin
            want = awaited_dates.pop_front();
            results_checked <= results_checked + 1;
            if (rsp_status !== want.status) begin
               errs++;
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_status);
            end
            if (rsp_epoch_seconds !== want.epoch) begin
               errs++;
               $display("%0t: epoch_seconds mismatch, expected %0d, actual %0d",
                        $time, $signed(want.epoch), rsp_epoch_seconds);
            end
         end
      end
      if (errs != 0) begin
         fail_count <= fail_count + errs;
      end
   end

   // During the pressure phase the receiver stops popping for a long time,
   // while the sender keeps offering bytes, so that both internal queues
   // fill and full has to rise.
   initial begin : hold_off
      wait (phase_no == PRESSURE_PHASE);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // A hung handshake must not leave the run going forever.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence: a directed set of strings with the offset at its reset
   // value, then random phases, each under a fresh offset. The first four
   // phases take the extremes of the offset, both at one day either way and
   // at the ends of the full 18 bits, and the fifth puts it back to zero.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int p;
      int v;
      int mark;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      running = 1'b1;

      // Stray text before any first flag is simply ignored.
      queue_tail("junk ");
      queue_text("Wed, 21 Oct 2015 07:28:00 GMT");
      queue_text("Thu, 01 Jan 1970 00:00:00 GMT");
      queue_text("Fri, 31 Dec 9999 23:59:59 GMT");
      // Year zero, day zero: a date before the start of the calendar.
      queue_text("Sat, 00 Jan 0000 00:00:00 GMT");
      // Day, hour, minute and second at their largest two-digit value, carried over.
      queue_text("Sun, 99 Feb 2024 99:99:99 GMT");
      queue_text("Mon, 123 Jan 2000 00:00:00 GMT");
      queue_text("Mon, 01 Jan 20151 00:00:00 GMT");
      // Month names that are unknown, in the wrong case, too long, too short.
      queue_text("Tue, 05 Foo 2001 01:02:03 GMT");
      queue_text("Tue, 05 mar 2001 01:02:03 GMT");
      queue_text("Tue, 05 Marc 2001 01:02:03 GMT");
      queue_text("Tue, 05 Ma 2001 01:02:03 GMT");
      // Empty day and year fields count as zero.
      queue_text("Tue,  Mar  12:34:56");
      // Signs, letters and other non-digits cut the numbers short.
      queue_text("Tue, 1x Aug 2-19 +1:a2:3Z GMT");
      // A parse abandoned twice before a string completes.
      queue_text("Wed, 21 Oct 20");
      queue_text("Wed, 21 Oc");
      queue_text("Thu, 29 Feb 2024 12:00:00 GMT");
      // Skipped bytes at both extremes of the byte range.
      put_byte(8'hFF, 1'b1);
      put_byte(8'h00, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(SPACE, 1'b0);
      queue_tail("7 Jun 1999 10:20:30 GMT");
      wait_quiet();

      mark = bytes_queued;
      p    = 1;
      while (p < 6 || bytes_queued - mark < RANDOM_BYTES) begin
         case (p)
            1:       v = 86400;
            2:       v = -86400;
            3:       v = 131071;
            4:       v = -131072;
            5:       v = 0;
            default: begin
               if ($urandom_range(0, 9) == 0) begin
                  v = $urandom_range(0, 262143) - 131072;
               end else begin
                  v = $urandom_range(0, 172800) - 86400;
               end
            end
         endcase
         write_zone(v);
         @(posedge clock);
         phase_no = p;
         steady   = (p == STEADY_PHASE);
         if (p == PRESSURE_PHASE) begin
            // Whole dates only, so that every string ends in a result.
            repeat (PRESSURE_DATES) queue_random_date(1'b0);
         end else begin
            repeat ((p == STEADY_PHASE) ? STEADY_DATES : PHASE_DATES) queue_random_item();
         end
         wait_quiet();
         p++;
      end

      if (fail_count == 0 && awaited_dates.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/hdep_pkg.sv
src/hdep_front.sv
src/hdep_queue.sv
src/hdep_back.sv
src/http_date_to_epoch_parser.sv
tb/sv/tb.sv
